// File: rtl/fhp_pkg.sv
// Shared constants, types and hash helper functions for the ECMP flow-hash path selector.
// Depends on nothing; every other file in rtl/ imports it.
package fhp_pkg;

	// Field widths fixed by the packet header
	localparam int ADDR_W    = 32;
	localparam int PROTO_W   = 8;
	localparam int PORT_W    = 16;
	localparam int CNT_IN_W  = 7;
	localparam int IDX_W     = 6;
	localparam int HASH_W    = 32;

	// Default upper bound on equal-cost paths
	localparam int MAX_PATHS_DEF = 64;

	// Stream packing widths
	localparam int S_TDATA_W = 104;
	localparam int M_TDATA_W = 40;

	// Protocols that carry a port pair in the key
	localparam logic [PROTO_W-1:0] PROTO_TCP  = 8'h06;
	localparam logic [PROTO_W-1:0] PROTO_UDP  = 8'h11;
	localparam logic [PROTO_W-1:0] PROTO_ACK0 = 8'hFC;
	localparam logic [PROTO_W-1:0] PROTO_ACK1 = 8'hFD;

	// Hash constants
	localparam logic [HASH_W-1:0] MUR_C1    = 32'hcc9e2d51;
	localparam logic [HASH_W-1:0] MUR_C2    = 32'h1b873593;
	localparam logic [HASH_W-1:0] MUR_N     = 32'he6546b64;
	localparam logic [HASH_W-1:0] MUR_F1    = 32'h85ebca6b;
	localparam logic [HASH_W-1:0] MUR_F2    = 32'hc2b2ae35;
	localparam logic [HASH_W-1:0] KEY_BYTES = 32'd12;

	typedef logic [HASH_W-1:0] word_t;

	function automatic word_t rotl15(input word_t v);
		return {v[16:0], v[31:17]};
	endfunction

	function automatic word_t rotl13(input word_t v);
		return {v[18:0], v[31:19]};
	endfunction

	// h = rotl(h ^ k, 13) * 5 + N, the times-five done as shift and add
	function automatic word_t mix_h(input word_t h, input word_t k);
		word_t r;
		r = rotl13(h ^ k);
		return (r << 2) + r + MUR_N;
	endfunction

endpackage

// File: rtl/ecmp_flow_hash_path_select_core.sv
// ECMP path selector top: input stream, hash pipeline, remainder pipeline, output skid.
// Depends on fhp_pkg, fhp_mix, fhp_fmix and fhp_mod.
//
// Usage:
//   s_axis carries one packet header per item; m_axis returns one result per item,
//   in order. cfg_valid/cfg_data write the hash seed (always ready); write it only
//   while no items are in flight.
//   Pipeline from input acceptance to m_axis_tvalid: 6 key/mix stages,
//   3 finalize stages, 8 remainder stages, 1 output register.
//   Throughput: one item per cycle while not stalled, set by the fully pipelined
//   datapath; each remainder stage retires four quotient bits.
//   Stall: when m_axis_tready is low the output register holds its item and one
//   more item lands in a skid register; the whole pipeline then freezes and
//   s_axis_tready drops (it is a register output, no combinational path from
//   m_axis_tready). Nothing is dropped or repeated.
//   Reset: arst_n clears all valid bits and sets the seed to zero; no clearing pass.
//   A zero path count gives no_route = 1 and path_index = 0; counts above
//   MAX_PATHS are clipped to MAX_PATHS.
module ecmp_flow_hash_path_select_core #(
	parameter int MAX_PATHS = fhp_pkg::MAX_PATHS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// tdata: src_addr[31:0], dst_addr[63:32], src_port[79:64], dst_port[95:80],
	//        path_count[102:96], zero pad
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [fhp_pkg::S_TDATA_W-1:0]   s_axis_tdata,
	// tuser: protocol[7:0]
	input  logic [fhp_pkg::PROTO_W-1:0]     s_axis_tuser,
	// tdata: path_index[5:0], flow_hash[37:6], zero pad
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [fhp_pkg::M_TDATA_W-1:0]   m_axis_tdata,
	// tuser: no_route[0]
	output logic                            m_axis_tuser,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [fhp_pkg::HASH_W-1:0]      cfg_data
);
	import fhp_pkg::*;

	localparam int CW = $clog2(MAX_PATHS + 1);

	logic          en;
	word_t         hash_seed_q;

	logic          mix_v, fm_v, md_v;
	word_t         mix_h_w, fm_h, md_h;
	logic [CW-1:0] mix_cnt, fm_cnt, md_cnt, md_rem;

	logic               res_none;
	logic [IDX_W-1:0]   res_idx;

	logic               out_valid_q, skid_valid_q;
	logic [IDX_W-1:0]   out_idx_q, skid_idx_q;
	logic               out_none_q, skid_none_q;
	word_t              out_hash_q, skid_hash_q;

	// Pipeline advances unless the skid register is occupied
	assign en            = ~skid_valid_q;
	assign s_axis_tready = en;
	assign cfg_ready     = 1'b1;

	// Seed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_seed_q <= '0;
		end else if (cfg_valid) begin
			hash_seed_q <= cfg_data;
		end
	end

	fhp_mix #(
		.MAX_PATHS (MAX_PATHS),
		.CW        (CW)
	) u_mix (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (s_axis_tvalid),
		.src_addr   (s_axis_tdata[31:0]),
		.dst_addr   (s_axis_tdata[63:32]),
		.protocol   (s_axis_tuser),
		.src_port   (s_axis_tdata[79:64]),
		.dst_port   (s_axis_tdata[95:80]),
		.path_count (s_axis_tdata[102:96]),
		.hash_seed  (hash_seed_q),
		.out_valid  (mix_v),
		.out_hash   (mix_h_w),
		.out_count  (mix_cnt)
	);

	fhp_fmix #(
		.CW (CW)
	) u_fmix (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (mix_v),
		.in_hash   (mix_h_w),
		.in_count  (mix_cnt),
		.out_valid (fm_v),
		.out_hash  (fm_h),
		.out_count (fm_cnt)
	);

	fhp_mod #(
		.CW (CW)
	) u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (fm_v),
		.in_hash   (fm_h),
		.in_count  (fm_cnt),
		.out_valid (md_v),
		.out_hash  (md_h),
		.out_count (md_cnt),
		.out_rem   (md_rem)
	);

	// Result fields from the last pipeline stage
	always_comb begin
		res_none = (md_cnt == '0);
		res_idx  = res_none ? '0 : IDX_W'(md_rem);
	end

	// Output register and skid control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || m_axis_tready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q  <= md_v;
			end
		end else if (md_v && en) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Output register and skid payload
	always_ff @(posedge clk) begin
		if (!out_valid_q || m_axis_tready) begin
			if (skid_valid_q) begin
				out_idx_q  <= skid_idx_q;
				out_none_q <= skid_none_q;
				out_hash_q <= skid_hash_q;
			end else begin
				out_idx_q  <= res_idx;
				out_none_q <= res_none;
				out_hash_q <= md_h;
			end
		end else if (en) begin
			skid_idx_q  <= res_idx;
			skid_none_q <= res_none;
			skid_hash_q <= md_h;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_none_q;
	assign m_axis_tdata  = {{(M_TDATA_W - HASH_W - IDX_W){1'b0}}, out_hash_q, out_idx_q};

`ifndef SYNTHESIS
	// Skid only fills behind an occupied output register
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid register valid while output register empty");

	// Skid fills only when the output was stalled the cycle before
	a_skid_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q && !$past(skid_valid_q) |-> $past(out_valid_q && !m_axis_tready))
		else $error("skid register filled without an output stall");

	// A no-route result carries index zero
	a_no_route_idx: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[IDX_W-1:0] == '0)
		else $error("no_route result with nonzero path index");
`endif

endmodule

// File: rtl/fhp_mix.sv
// Key build, block mixing, length fold and first finalize shift-xor stages (s1..s6) of the flow hash.
// Depends on fhp_pkg.
module fhp_mix #(
	parameter int MAX_PATHS = fhp_pkg::MAX_PATHS_DEF,
	parameter int CW        = $clog2(MAX_PATHS + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic [fhp_pkg::ADDR_W-1:0]    src_addr,
	input  logic [fhp_pkg::ADDR_W-1:0]    dst_addr,
	input  logic [fhp_pkg::PROTO_W-1:0]   protocol,
	input  logic [fhp_pkg::PORT_W-1:0]    src_port,
	input  logic [fhp_pkg::PORT_W-1:0]    dst_port,
	input  logic [fhp_pkg::CNT_IN_W-1:0]  path_count,
	input  logic [fhp_pkg::HASH_W-1:0]    hash_seed,
	output logic                          out_valid,
	output logic [fhp_pkg::HASH_W-1:0]    out_hash,
	output logic [CW-1:0]                 out_count
);
	import fhp_pkg::*;

	logic    use_ports;
	word_t   ports;
	logic [CW-1:0] cnt_sat;

	logic    v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	word_t   w0_s1, w1_s1, w2_s1;
	word_t   k0_s2, k1_s2, k2_s2;
	word_t   k0_s3, k1_s3, k2_s3;
	word_t   h_s4, k1_s4, k2_s4;
	word_t   h_s5, k2_s5;
	word_t   h_s6;
	word_t   h_end;
	logic [CW-1:0] cnt_s1, cnt_s2, cnt_s3, cnt_s4, cnt_s5, cnt_s6;

	// Port word only for protocols that carry ports; path count clipped to MAX_PATHS
	always_comb begin
		use_ports = (protocol == PROTO_TCP) || (protocol == PROTO_UDP) ||
		            (protocol == PROTO_ACK0) || (protocol == PROTO_ACK1);
		ports = use_ports ? {dst_port, src_port} : '0;
		if (int'(path_count) > MAX_PATHS) begin
			cnt_sat = CW'(MAX_PATHS);
		end else begin
			cnt_sat = CW'(path_count);
		end
	end

	// Last block and length fold; the first shift-xor is applied into s6
	always_comb begin
		h_end = mix_h(h_s5, k2_s5) ^ KEY_BYTES;
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// Payload: key words, per-block multiplies, then the serial h chain
	always_ff @(posedge clk) begin
		if (en) begin
			w0_s1  <= src_addr;
			w1_s1  <= dst_addr;
			w2_s1  <= ports;
			cnt_s1 <= cnt_sat;

			k0_s2  <= w0_s1 * MUR_C1;
			k1_s2  <= w1_s1 * MUR_C1;
			k2_s2  <= w2_s1 * MUR_C1;
			cnt_s2 <= cnt_s1;

			k0_s3  <= rotl15(k0_s2) * MUR_C2;
			k1_s3  <= rotl15(k1_s2) * MUR_C2;
			k2_s3  <= rotl15(k2_s2) * MUR_C2;
			cnt_s3 <= cnt_s2;

			h_s4   <= mix_h(hash_seed, k0_s3);
			k1_s4  <= k1_s3;
			k2_s4  <= k2_s3;
			cnt_s4 <= cnt_s3;

			h_s5   <= mix_h(h_s4, k1_s4);
			k2_s5  <= k2_s4;
			cnt_s5 <= cnt_s4;

			h_s6   <= h_end ^ (h_end >> 16);
			cnt_s6 <= cnt_s5;
		end
	end

	assign out_valid = v_s6;
	assign out_hash  = h_s6;
	assign out_count = cnt_s6;

endmodule

// File: rtl/fhp_fmix.sv
// Hash finalization stages (s7..s9): two multiplies, each behind its own register.
// Depends on fhp_pkg.
module fhp_fmix #(
	parameter int CW = 7
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [fhp_pkg::HASH_W-1:0]  in_hash,
	input  logic [CW-1:0]               in_count,
	output logic                        out_valid,
	output logic [fhp_pkg::HASH_W-1:0]  out_hash,
	output logic [CW-1:0]               out_count
);
	import fhp_pkg::*;

	logic    v_s7, v_s8, v_s9;
	word_t   h_s7, h_s8, h_s9;
	word_t   x13;
	logic [CW-1:0] cnt_s7, cnt_s8, cnt_s9;

	assign x13 = h_s7 ^ (h_s7 >> 13);

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else if (en) begin
			v_s7 <= in_valid;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (en) begin
			h_s7   <= in_hash * MUR_F1;
			cnt_s7 <= in_count;
			h_s8   <= x13 * MUR_F2;
			cnt_s8 <= cnt_s7;
			h_s9   <= h_s8 ^ (h_s8 >> 16);
			cnt_s9 <= cnt_s8;
		end
	end

	assign out_valid = v_s9;
	assign out_hash  = h_s9;
	assign out_count = cnt_s9;

endmodule

// File: rtl/fhp_mod.sv
// Pipelined restoring remainder: hash modulo path count, four quotient bits per stage.
// Depends on fhp_pkg.
module fhp_mod #(
	parameter int CW = 7
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [fhp_pkg::HASH_W-1:0]  in_hash,
	input  logic [CW-1:0]               in_count,
	output logic                        out_valid,
	output logic [fhp_pkg::HASH_W-1:0]  out_hash,
	output logic [CW-1:0]               out_count,
	output logic [CW-1:0]               out_rem
);
	import fhp_pkg::*;

	localparam int BPS    = 4;
	localparam int STAGES = HASH_W / BPS;

	logic          v_s   [STAGES];
	word_t         h_s   [STAGES];
	logic [CW-1:0] cnt_s [STAGES];
	logic [CW-1:0] rem_s [STAGES];

	// Shift in BPS dividend bits, subtracting the divisor where it fits
	function automatic logic [CW-1:0] rem_step(input logic [CW-1:0] r_in,
	                                           input logic [BPS-1:0] bits,
	                                           input logic [CW-1:0] d);
		logic [CW:0]   t;
		logic [CW-1:0] r;
		r = r_in;
		for (int i = BPS - 1; i >= 0; i--) begin
			t = {r, bits[i]};
			if (t >= {1'b0, d}) begin
				t = t - {1'b0, d};
			end
			r = t[CW-1:0];
		end
		return r;
	endfunction

	for (genvar j = 0; j < STAGES; j++) begin : g_stage
		logic          v_in;
		word_t         h_in;
		logic [CW-1:0] cnt_in;
		logic [CW-1:0] rem_in;

		if (j == 0) begin : g_first
			assign v_in   = in_valid;
			assign h_in   = in_hash;
			assign cnt_in = in_count;
			assign rem_in = '0;
		end else begin : g_next
			assign v_in   = v_s[j-1];
			assign h_in   = h_s[j-1];
			assign cnt_in = cnt_s[j-1];
			assign rem_in = rem_s[j-1];
		end

		// Stage valid
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j] <= 1'b0;
			end else if (en) begin
				v_s[j] <= v_in;
			end
		end

		// Stage payload
		always_ff @(posedge clk) begin
			if (en) begin
				h_s[j]   <= h_in;
				cnt_s[j] <= cnt_in;
				rem_s[j] <= rem_step(rem_in, h_in[HASH_W-1-BPS*j -: BPS], cnt_in);
			end
		end
	end

	assign out_valid = v_s[STAGES-1];
	assign out_hash  = h_s[STAGES-1];
	assign out_count = cnt_s[STAGES-1];
	assign out_rem   = rem_s[STAGES-1];

endmodule
